/* hdl/npt_pkg.sv */
// Shared types, constants and seed table for the n-th prime finder.
package npt_pkg;

	localparam int INDEX_W         = 13;
	localparam int PRIME_W         = 16;
	localparam int MAX_PRIMES_DEF  = 4096;
	localparam int PRIME_WIDTH_DEF = 16;
	localparam int SEED_COUNT      = 4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_idx;
		logic start_ext;
		logic step_cand;
		logic clr_i;
		logic inc_i;
		logic rd_trial;
		logic rd_result;
		logic load_q;
		logic div_start;
		logic div_step;
		logic commit;
		logic set_ok;
		logic set_err;
	} npt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_bad;
		logic have;
		logic cand_over;
		logic i_end;
		logic sq_above;
		logic div_last;
		logic rem_zero;
	} npt_sts_t;

	// The first four primes are fixed and never stored in the memory.
	function automatic logic [7:0] seed_prime(input logic [1:0] sel);
		logic [7:0] val;
		case (sel)
			2'd0:    val = 8'd2;
			2'd1:    val = 8'd3;
			2'd2:    val = 8'd5;
			default: val = 8'd7;
		endcase
		return val;
	endfunction

endpackage

/* hdl/nth_prime_trial_division.sv */
// Top level: returns the n-th prime, extending a cached table by 6k+-1 trial division.
// A request already covered by the table goes through S_CHECK, S_RDRES and S_OUT before its result
// is registered, and an index out of range, or a candidate beyond the prime width, ends in S_ERR.
// Extending steps the candidate, then for each trial divisor reads it, squares it, compares and
// runs the bit-serial remainder unit on it; a prime found is committed and the table checked again.
// One request is in work at a time, and a new one is taken while the previous result waits;
// reset clears the controller and restores the four seed primes, with no memory clearing pass.
module nth_prime_trial_division import npt_pkg::*; #(
	parameter int MAX_PRIMES  = MAX_PRIMES_DEF,
	parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [INDEX_W-1:0] index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PRIME_W-1:0] prime,
	output logic               error
);

	npt_cmd_t cmd;
	npt_sts_t sts;

	npt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	npt_datapath #(
		.MAX_PRIMES  (MAX_PRIMES),
		.PRIME_WIDTH (PRIME_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.index  (index),
		.cmd    (cmd),
		.sts    (sts),
		.prime  (prime),
		.error  (error)
	);

endmodule

/* hdl/npt_datapath.sv */
// Datapath: prime table memory, candidate wheel, square compare and iterative remainder unit.
module npt_datapath import npt_pkg::*; #(
	parameter int MAX_PRIMES  = MAX_PRIMES_DEF,
	parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [INDEX_W-1:0] index,
	input  npt_cmd_t           cmd,
	output npt_sts_t           sts,
	output logic [PRIME_W-1:0] prime,
	output logic               error
);

	localparam int PW  = PRIME_WIDTH;
	localparam int CDW = PW + 1;
	localparam int QW  = 2 * PW;
	localparam int CW  = $clog2(MAX_PRIMES + 1);
	localparam int AW  = $clog2(MAX_PRIMES);
	localparam int WW  = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int DCW = $clog2(PW);

	logic [INDEX_W-1:0] idx_q;
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      last_q;
	logic               last_ph_q;
	logic [CDW-1:0]     cand_q;
	logic               ph_q;
	logic [CW-1:0]      i_q;
	logic [PW-1:0]      q_q;
	logic [QW-1:0]      qq_q;
	logic [PW-1:0]      rem_q;
	logic [PW-1:0]      dvd_q;
	logic [DCW-1:0]     dcnt_q;

	logic [PW-1:0]      prime_mem [MAX_PRIMES];
	logic [PW-1:0]      mem_rd_q;
	logic               seed_sel_q;
	logic [1:0]         seed_q;

	logic [PRIME_W-1:0] prime_res_q;
	logic               error_res_q;

	logic [WW-1:0]      idx_m1;
	logic [WW-1:0]      rd_sel;
	logic [AW-1:0]      rd_addr;
	logic               rd_en;
	logic [PW-1:0]      rdata;
	logic [PW:0]        div_t;
	logic [PW:0]        div_diff;
	logic               div_ge;
	logic [PW-1:0]      rem_nx;

	assign idx_m1  = WW'(idx_q) - WW'(1);
	assign rd_sel  = cmd.rd_result ? idx_m1 : WW'(i_q);
	assign rd_addr = rd_sel[AW-1:0];
	assign rd_en   = cmd.rd_result | cmd.rd_trial;
	assign rdata   = seed_sel_q ? PW'(seed_prime(seed_q)) : mem_rd_q;

	// One restoring step of the remainder: shift in a dividend bit, subtract if it fits.
	assign div_t    = {rem_q, dvd_q[PW-1]};
	assign div_diff = div_t - {1'b0, q_q};
	assign div_ge   = div_t >= {1'b0, q_q};
	assign rem_nx   = div_ge ? div_diff[PW-1:0] : div_t[PW-1:0];

	always_comb begin
		sts.idx_bad   = (idx_q == '0) || (WW'(idx_q) > WW'(MAX_PRIMES));
		sts.have      = WW'(count_q) >= WW'(idx_q);
		sts.cand_over = cand_q[PW];
		sts.i_end     = i_q >= count_q;
		sts.sq_above  = qq_q > QW'(cand_q);
		sts.div_last  = dcnt_q == DCW'(PW - 1);
		sts.rem_zero  = rem_q == '0;
	end

	// Table bookkeeping: the count and the last prime found survive between requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CW'(SEED_COUNT);
			last_q    <= PW'(7);
			last_ph_q <= 1'b1;
		end else if (cmd.commit) begin
			count_q   <= count_q + CW'(1);
			last_q    <= cand_q[PW-1:0];
			last_ph_q <= ph_q;
		end
	end

	// Working registers; ph_q is set when the candidate is 1 mod 6, so the next step is +4.
	always_ff @(posedge clk) begin
		if (cmd.load_idx) begin
			idx_q <= index;
		end
		if (cmd.start_ext) begin
			cand_q <= CDW'(last_q);
			ph_q   <= last_ph_q;
		end else if (cmd.step_cand) begin
			cand_q <= cand_q + (ph_q ? CDW'(4) : CDW'(2));
			ph_q   <= ~ph_q;
		end
		if (cmd.clr_i) begin
			i_q <= '0;
		end else if (cmd.inc_i) begin
			i_q <= i_q + CW'(1);
		end
		if (cmd.load_q) begin
			q_q <= rdata;
		end
		qq_q <= QW'(q_q) * QW'(q_q);
		if (cmd.div_start) begin
			rem_q  <= '0;
			dvd_q  <= cand_q[PW-1:0];
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_nx;
			dvd_q  <= {dvd_q[PW-2:0], 1'b0};
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if (cmd.set_ok) begin
			prime_res_q <= PRIME_W'(rdata);
			error_res_q <= 1'b0;
		end else if (cmd.set_err) begin
			prime_res_q <= '0;
			error_res_q <= 1'b1;
		end
	end

	// Prime table; the four seeds are served from constants instead of the memory.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			prime_mem[count_q[AW-1:0]] <= cand_q[PW-1:0];
		end
		if (rd_en) begin
			mem_rd_q   <= prime_mem[rd_addr];
			seed_sel_q <= rd_sel < WW'(SEED_COUNT);
			seed_q     <= rd_sel[1:0];
		end
	end

	assign prime = prime_res_q;
	assign error = error_res_q;

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (WW'(count_q) < WW'(MAX_PRIMES)))
		else $error("prime committed with the table full");

	a_commit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !cand_q[PW])
		else $error("committed prime exceeds the prime width");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (q_q != '0))
		else $error("remainder step with a zero divisor");

endmodule

/* hdl/npt_ctrl.sv */
// Controller: sequences table lookup, candidate stepping and trial division.
module npt_ctrl import npt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  npt_sts_t sts,
	output npt_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_STEP  = 4'd2;
	localparam logic [3:0] S_TEST  = 4'd3;
	localparam logic [3:0] S_TRD   = 4'd4;
	localparam logic [3:0] S_TQ    = 4'd5;
	localparam logic [3:0] S_TSQ   = 4'd6;
	localparam logic [3:0] S_TCMP  = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_DCHK  = 4'd9;
	localparam logic [3:0] S_FOUND = 4'd10;
	localparam logic [3:0] S_RDRES = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;
	localparam logic [3:0] S_ERR   = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = ~out_valid_q | out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_idx = 1'b1;
					state_nx     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.idx_bad) begin
					state_nx = S_ERR;
				end else if (sts.have) begin
					state_nx = S_RDRES;
				end else begin
					cmd.start_ext = 1'b1;
					state_nx      = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step_cand = 1'b1;
				state_nx      = S_TEST;
			end
			S_TEST: begin
				if (sts.cand_over) begin
					state_nx = S_ERR;
				end else begin
					cmd.clr_i = 1'b1;
					state_nx  = S_TRD;
				end
			end
			S_TRD: begin
				if (sts.i_end) begin
					state_nx = S_FOUND;
				end else begin
					cmd.rd_trial = 1'b1;
					state_nx     = S_TQ;
				end
			end
			S_TQ: begin
				cmd.load_q = 1'b1;
				state_nx   = S_TSQ;
			end
			S_TSQ: begin
				state_nx = S_TCMP;
			end
			S_TCMP: begin
				// Once the divisor squared passes the candidate, no larger divisor can matter.
				if (sts.sq_above) begin
					state_nx = S_FOUND;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = S_DCHK;
				end
			end
			S_DCHK: begin
				if (sts.rem_zero) begin
					state_nx = S_STEP;
				end else begin
					cmd.inc_i = 1'b1;
					state_nx  = S_TRD;
				end
			end
			S_FOUND: begin
				cmd.commit = 1'b1;
				state_nx   = S_CHECK;
			end
			S_RDRES: begin
				cmd.rd_result = 1'b1;
				state_nx      = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.set_ok = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_ERR: begin
				if (slot_free) begin
					cmd.set_err = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.set_ok || cmd.set_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_ok || cmd.set_err) |-> slot_free)
		else $error("result register loaded while a result is still waiting");

	a_found_rechecks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOUND) |=> (state_q == S_CHECK))
		else $error("new prime not followed by a table check");

	a_over_errors: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEST && sts.cand_over) |=> (state_q == S_ERR))
		else $error("candidate beyond the prime width was tested");

endmodule
